FILE: rtl/core/rgbw_pkg.sv
// Shared types and constants for the RGB to RGBW pixel converter.
// No dependencies; imported by every module of the block.
`default_nettype none
package rgbw_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned RegIdxW  = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_WHITE_ENABLE   = 3'd0,
    REG_TEMP_RED       = 3'd1,
    REG_TEMP_GREEN     = 3'd2,
    REG_TEMP_BLUE      = 3'd3,
    REG_BLUE_COMP      = 3'd4,
    REG_RED_POSITION   = 3'd5,
    REG_GREEN_POSITION = 3'd6,
    REG_BLUE_POSITION  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    SLOT_ZERO = 2'd0,
    SLOT_ONE  = 2'd1,
    SLOT_TWO  = 2'd2,
    SLOT_NONE = 2'd3
  } slot_t;

  // Reciprocal of five, exact for dividends below 2**14
  localparam logic [11:0] RecipFive = 12'd3277;
  localparam int unsigned RecipFiveShift = 14;
  localparam logic [16:0] RoundHalf = 17'd127;

  typedef struct packed {
    logic       white_enable;
    logic [7:0] temp_red;
    logic [7:0] temp_green;
    logic [7:0] temp_blue;
    logic       blue_comp;
    logic [1:0] red_position;
    logic [1:0] green_position;
    logic [1:0] blue_position;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } pix_t;

endpackage
`default_nettype wire

FILE: rtl/core/rgbw_cfg_regs.sv
// APB-style configuration register file for the converter.
// Depends on rgbw_pkg for the register map and the cfg_t struct.
`default_nettype none
module rgbw_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [rgbw_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output rgbw_pkg::cfg_t                 cfg
);
  import rgbw_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_WHITE_ENABLE:   cfg_nxt.white_enable   = pwdata[0];
        REG_TEMP_RED:       cfg_nxt.temp_red       = pwdata[7:0];
        REG_TEMP_GREEN:     cfg_nxt.temp_green     = pwdata[7:0];
        REG_TEMP_BLUE:      cfg_nxt.temp_blue      = pwdata[7:0];
        REG_BLUE_COMP:      cfg_nxt.blue_comp      = pwdata[0];
        REG_RED_POSITION:   cfg_nxt.red_position   = pwdata[1:0];
        REG_GREEN_POSITION: cfg_nxt.green_position = pwdata[1:0];
        REG_BLUE_POSITION:  cfg_nxt.blue_position  = pwdata[1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white_enable   <= 1'b0;
      cfg_r.temp_red       <= 8'd255;
      cfg_r.temp_green     <= 8'd177;
      cfg_r.temp_blue      <= 8'd109;
      cfg_r.blue_comp      <= 1'b0;
      cfg_r.red_position   <= SLOT_ONE;
      cfg_r.green_position <= SLOT_ZERO;
      cfg_r.blue_position  <= SLOT_TWO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (idx)
      REG_WHITE_ENABLE:   prdata = {31'd0, cfg_r.white_enable};
      REG_TEMP_RED:       prdata = {24'd0, cfg_r.temp_red};
      REG_TEMP_GREEN:     prdata = {24'd0, cfg_r.temp_green};
      REG_TEMP_BLUE:      prdata = {24'd0, cfg_r.temp_blue};
      REG_BLUE_COMP:      prdata = {31'd0, cfg_r.blue_comp};
      REG_RED_POSITION:   prdata = {30'd0, cfg_r.red_position};
      REG_GREEN_POSITION: prdata = {30'd0, cfg_r.green_position};
      REG_BLUE_POSITION:  prdata = {30'd0, cfg_r.blue_position};
      default:            prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/rgbw_select.sv
// Stages one and two: cross products of the colours with the temperature,
// then choice of the white byte. Depends on rgbw_pkg.
`default_nettype none
module rgbw_select (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rgbw_pkg::cfg_t cfg,
  input  wire logic           req_valid,
  input  wire logic [7:0]     red,
  input  wire logic [7:0]     green,
  input  wire logic [7:0]     blue,
  output rgbw_pkg::pix_t      pix
);
  import rgbw_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_red_r, s1_green_r, s1_blue_r;
  logic [15:0] rg_r, gr_r, rb_r, br_r, gb_r, bg_r;
  logic        red_min, green_min;
  pix_t        s2_r;
  pix_t        s2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_red_r   <= red;
    s1_green_r <= green;
    s1_blue_r  <= blue;
    rg_r       <= red   * cfg.temp_green;
    gr_r       <= green * cfg.temp_red;
    rb_r       <= red   * cfg.temp_blue;
    br_r       <= blue  * cfg.temp_red;
    gb_r       <= green * cfg.temp_blue;
    bg_r       <= blue  * cfg.temp_green;
  end

  assign red_min   = (rg_r <= gr_r) && (rb_r <= br_r);
  assign green_min = (gb_r <= bg_r);

  always_comb begin
    s2_nxt       = '0;
    s2_nxt.valid = s1_valid_r;
    s2_nxt.red   = s1_red_r;
    s2_nxt.green = s1_green_r;
    s2_nxt.blue  = s1_blue_r;
    if (!cfg.white_enable) begin
      s2_nxt.white = 8'd0;
    end else if (red_min) begin
      s2_nxt.white = s1_red_r;
    end else if (green_min) begin
      s2_nxt.white = s1_green_r;
    end else begin
      s2_nxt.white = s1_blue_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
    s2_r.red   <= s2_nxt.red;
    s2_r.green <= s2_nxt.green;
    s2_r.blue  <= s2_nxt.blue;
    s2_r.white <= s2_nxt.white;
  end

  assign pix = s2_r;

endmodule
`default_nettype wire

FILE: rtl/core/rgbw_reduce.sv
// Stages three and four: white times temperature, rounded divide by 255
// and clamped subtraction from each colour. Depends on rgbw_pkg.
`default_nettype none
module rgbw_reduce (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rgbw_pkg::cfg_t cfg,
  input  wire rgbw_pkg::pix_t pix_in,
  output rgbw_pkg::pix_t      pix_out
);
  import rgbw_pkg::*;

  pix_t        s3_r;
  logic [16:0] wr_r, wg_r, wb_r;
  logic [7:0]  loss_red, loss_green, loss_blue;
  pix_t        s4_r;
  pix_t        s4_nxt;

  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] sum;
    sum = x + {8'd0, x[16:8]} + 17'd1;
    return sum[15:8];
  endfunction

  function automatic logic [7:0] clamp_sub(input logic [7:0] c, input logic [7:0] l);
    return (l >= c) ? 8'd0 : (c - l);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else begin
      s3_r.valid <= pix_in.valid;
    end
    s3_r.red   <= pix_in.red;
    s3_r.green <= pix_in.green;
    s3_r.blue  <= pix_in.blue;
    s3_r.white <= pix_in.white;
    wr_r <= {1'b0, {8'd0, pix_in.white} * {8'd0, cfg.temp_red}}   + RoundHalf;
    wg_r <= {1'b0, {8'd0, pix_in.white} * {8'd0, cfg.temp_green}} + RoundHalf;
    wb_r <= {1'b0, {8'd0, pix_in.white} * {8'd0, cfg.temp_blue}}  + RoundHalf;
  end

  assign loss_red   = div255(wr_r);
  assign loss_green = div255(wg_r);
  assign loss_blue  = div255(wb_r);

  always_comb begin
    s4_nxt       = s3_r;
    s4_nxt.red   = clamp_sub(s3_r.red,   loss_red);
    s4_nxt.green = clamp_sub(s3_r.green, loss_green);
    s4_nxt.blue  = clamp_sub(s3_r.blue,  loss_blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else begin
      s4_r.valid <= s4_nxt.valid;
    end
    s4_r.red   <= s4_nxt.red;
    s4_r.green <= s4_nxt.green;
    s4_r.blue  <= s4_nxt.blue;
    s4_r.white <= s4_nxt.white;
  end

  assign pix_out = s4_r;

endmodule
`default_nettype wire

FILE: rtl/core/rgbw_finish.sv
// Stage five: blue correction of the white byte and slot placement,
// into the output registers. Depends on rgbw_pkg.
`default_nettype none
module rgbw_finish (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rgbw_pkg::cfg_t cfg,
  input  wire rgbw_pkg::pix_t pix_in,
  output logic                out_valid,
  output logic [7:0]          out_slot_zero,
  output logic [7:0]          out_slot_one,
  output logic [7:0]          out_slot_two,
  output logic [7:0]          out_white
);
  import rgbw_pkg::*;

  logic [10:0] five_w;
  logic [10:0] diff;
  logic [22:0] quot;
  logic [7:0]  white_nxt;
  logic [7:0]  slot0_nxt, slot1_nxt, slot2_nxt;
  logic        valid_r;
  logic [7:0]  slot0_r, slot1_r, slot2_r, white_r;

  function automatic logic [7:0] pick(input pix_t p, input cfg_t c, input slot_t s);
    logic [7:0] v;
    v = 8'd0;
    if (slot_t'(c.red_position) == s) v = p.red;
    if (slot_t'(c.green_position) == s) v = p.green;
    if (slot_t'(c.blue_position) == s) v = p.blue;
    return v;
  endfunction

  assign five_w = {pix_in.white, 2'b00} + {3'd0, pix_in.white};
  assign diff   = five_w - {3'd0, pix_in.blue};
  assign quot   = diff * RecipFive;

  always_comb begin
    white_nxt = pix_in.white;
    if (cfg.white_enable && cfg.blue_comp) begin
      white_nxt = (five_w > {3'd0, pix_in.blue}) ?
                  quot[RecipFiveShift+7:RecipFiveShift] : 8'd0;
    end
  end

  assign slot0_nxt = pick(pix_in, cfg, SLOT_ZERO);
  assign slot1_nxt = pick(pix_in, cfg, SLOT_ONE);
  assign slot2_nxt = pick(pix_in, cfg, SLOT_TWO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= pix_in.valid;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
    slot2_r <= slot2_nxt;
    white_r <= white_nxt;
  end

  assign out_valid     = valid_r;
  assign out_slot_zero = slot0_r;
  assign out_slot_one  = slot1_r;
  assign out_slot_two  = slot2_r;
  assign out_white     = white_r;

endmodule
`default_nettype wire

FILE: rtl/core/rgb_to_rgbw_pixel_converter_top.sv
// Top level of the RGB to RGBW pixel converter.
// Instantiates rgbw_cfg_regs, rgbw_select, rgbw_reduce and rgbw_finish.
//
// One pixel is taken every clock (busy is always low) and its result
// appears on the out_ ports, marked by out_valid, after it has passed
// through the cross products, white choice, white times temperature,
// clamped subtraction, then blue correction and slot placement, one
// register stage each. The receiver cannot stall, so results must be taken
// as they come. Change configuration only while no request is in flight.
`default_nettype none
module rgb_to_rgbw_pixel_converter_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [7:0]                in_red,
  input  wire logic [7:0]                in_green,
  input  wire logic [7:0]                in_blue,
  output logic                           out_valid,
  output logic [7:0]                     out_slot_zero,
  output logic [7:0]                     out_slot_one,
  output logic [7:0]                     out_slot_two,
  output logic [7:0]                     out_white,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [rgbw_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready
);
  import rgbw_pkg::*;

  cfg_t cfg;
  pix_t sel_pix;
  pix_t red_pix;

  assign busy = 1'b0;

  rgbw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbw_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .req_valid (start & ~busy),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .pix       (sel_pix)
  );

  rgbw_reduce u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .pix_in  (sel_pix),
    .pix_out (red_pix)
  );

  rgbw_finish u_finish (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .pix_in        (red_pix),
    .out_valid     (out_valid),
    .out_slot_zero (out_slot_zero),
    .out_slot_one  (out_slot_one),
    .out_slot_two  (out_slot_two),
    .out_white     (out_white)
  );

endmodule
`default_nettype wire
